### rtl/itdg_pkg.sv
package itdg_pkg;

  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned DIGITS   = 10;
  localparam int unsigned BCD_W    = 4 * DIGITS;
  localparam int unsigned IDX_W    = 4;
  localparam int unsigned SHIFT_CW = 5;

  localparam logic [CHAR_W-1:0] SEP_RESET  = 8'd44;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

  // Digit positions, counted from the billions digit.
  localparam logic [IDX_W-1:0] IDX_BILLIONS  = 4'd0;
  localparam logic [IDX_W-1:0] IDX_MILLIONS  = 4'd3;
  localparam logic [IDX_W-1:0] IDX_THOUSANDS = 4'd6;
  localparam logic [IDX_W-1:0] IDX_UNITS     = 4'd9;

  localparam logic [SHIFT_CW-1:0] SHIFT_LAST = 5'd31;

  // Character source for one output beat.
  localparam logic [1:0] SEL_SIGN  = 2'd0;
  localparam logic [1:0] SEL_DIGIT = 2'd1;
  localparam logic [1:0] SEL_SEP   = 2'd2;

  typedef struct packed {
    logic       load;
    logic       shift;
    logic       set_idx;
    logic       emit;
    logic [1:0] sel;
    logic       advance;
  } itdg_cmd_t;

  typedef struct packed {
    logic conv_done;
    logic neg;
    logic out_free;
    logic idx_last;
    logic idx_group;
  } itdg_sts_t;

endpackage

### rtl/itdg_if.sv
interface itdg_in_if
  import itdg_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

interface itdg_out_if
  import itdg_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_out;
  logic              last;

  modport source (output valid, output char_out, output last, input ready);
  modport sink (input valid, input char_out, input last, output ready);
endinterface

### rtl/itdg_dp.sv
module itdg_dp
  import itdg_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  itdg_cmd_t                 cmd_i,
  output itdg_sts_t                 sts_o,
  input  logic signed [VALUE_W-1:0] value_i,
  input  logic                      cfg_we_i,
  input  logic [CHAR_W-1:0]         cfg_wdata_i,
  input  logic                      out_ready_i,
  output logic                      out_valid_o,
  output logic [CHAR_W-1:0]         char_o,
  output logic                      last_o
);

  logic [VALUE_W-1:0]  mag_q;
  logic [BCD_W-1:0]    bcd_q;
  logic [BCD_W-1:0]    bcd_corr;
  logic [SHIFT_CW-1:0] cnt_q;
  logic [IDX_W-1:0]    idx_q;
  logic [IDX_W-1:0]    lead_idx;
  logic                neg_q;
  logic [CHAR_W-1:0]   sep_q;
  logic                out_valid_q;
  logic [CHAR_W-1:0]   char_q;
  logic                last_q;
  logic [CHAR_W-1:0]   char_d;
  logic [3:0]          dig [DIGITS];
  logic [3:0]          dig_cur;

  // Digit 0 is the billions digit, held in the top nibble.
  for (genvar k = 0; k < DIGITS; k++) begin : g_dig
    assign dig[k] = bcd_q[BCD_W-1-4*k -: 4];
  end

  assign dig_cur = dig[idx_q];

  // Add three to every nibble of five or more before each shift.
  always_comb begin
    for (int k = 0; k < DIGITS; k++) begin
      bcd_corr[4*k +: 4] = (bcd_q[4*k +: 4] >= 4'd5) ? bcd_q[4*k +: 4] + 4'd3
                                                      : bcd_q[4*k +: 4];
    end
  end

  // First nonzero digit, or the units digit when the value is zero.
  always_comb begin
    lead_idx = IDX_UNITS;
    for (int k = DIGITS - 1; k >= 0; k--) begin
      if (dig[k] != 4'd0) begin
        lead_idx = IDX_W'(k);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mag_q <= value_i[VALUE_W-1] ? (VALUE_W'(0) - unsigned'(value_i)) : unsigned'(value_i);
      bcd_q <= '0;
    end else if (cmd_i.shift) begin
      mag_q <= {mag_q[VALUE_W-2:0], 1'b0};
      bcd_q <= {bcd_corr[BCD_W-2:0], mag_q[VALUE_W-1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
      neg_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        cnt_q <= '0;
        neg_q <= value_i[VALUE_W-1];
      end else if (cmd_i.shift) begin
        cnt_q <= cnt_q + SHIFT_CW'(1);
      end
      if (cmd_i.set_idx) begin
        idx_q <= lead_idx;
      end else if (cmd_i.advance) begin
        idx_q <= idx_q + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_q <= SEP_RESET;
    end else if (cfg_we_i) begin
      sep_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    case (cmd_i.sel)
      SEL_SIGN:  char_d = CHAR_MINUS;
      SEL_DIGIT: char_d = CHAR_ZERO + {4'd0, dig_cur};
      SEL_SEP:   char_d = sep_q;
      default:   char_d = sep_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      char_q <= char_d;
      last_q <= (cmd_i.sel == SEL_DIGIT) && (idx_q == IDX_UNITS);
    end
  end

  // The sequencer shifts on every conversion cycle, so the count alone marks
  // the final shift.
  assign sts_o.conv_done = (cnt_q == SHIFT_LAST);
  assign sts_o.neg       = neg_q;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;
  assign sts_o.idx_last  = (idx_q == IDX_UNITS);
  assign sts_o.idx_group = (idx_q == IDX_BILLIONS) || (idx_q == IDX_MILLIONS) ||
                           (idx_q == IDX_THOUSANDS);

  assign out_valid_o = out_valid_q;
  assign char_o      = char_q;
  assign last_o      = last_q;

endmodule

### rtl/itdg_ctrl.sv
module itdg_ctrl
  import itdg_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  itdg_sts_t sts_i,
  output itdg_cmd_t cmd_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CONV  = 3'd1;
  localparam logic [2:0] ST_LEAD  = 3'd2;
  localparam logic [2:0] ST_SIGN  = 3'd3;
  localparam logic [2:0] ST_DIGIT = 3'd4;
  localparam logic [2:0] ST_SEP   = 3'd5;

  logic [2:0] state_q;
  logic [2:0] state_d;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.sel     = SEL_DIGIT;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd_o.shift = 1'b1;
        if (sts_i.conv_done) begin
          state_d = ST_LEAD;
        end
      end
      ST_LEAD: begin
        cmd_o.set_idx = 1'b1;
        state_d       = sts_i.neg ? ST_SIGN : ST_DIGIT;
      end
      ST_SIGN: begin
        cmd_o.sel = SEL_SIGN;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.idx_last) begin
            state_d = ST_IDLE;
          end else if (sts_i.idx_group) begin
            state_d = ST_SEP;
          end else begin
            cmd_o.advance = 1'b1;
          end
        end
      end
      ST_SEP: begin
        cmd_o.sel = SEL_SEP;
        if (sts_i.out_free) begin
          cmd_o.emit    = 1'b1;
          cmd_o.advance = 1'b1;
          state_d       = ST_DIGIT;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

endmodule

### rtl/int_to_decimal_grouped_core.sv
// Signed 32-bit integer to grouped decimal ASCII. Each input beat carries one
// two's complement value; the block answers with its decimal text, one
// character per output beat, most significant first: a '-' for a negative
// value, then the digits of the magnitude without leading zeros, with the
// separator byte placed after the billions, millions and thousands digits
// once the first digit has been printed. The units digit is flagged with
// last. The most negative value prints as its true magnitude 2147483648.
// Timing: after an input beat is taken, a double-dabble converter shifts the
// magnitude into ten BCD digits at one bit per cycle, a lead state locates
// the leading digit, and then one character is produced per cycle while the
// output side keeps up. An item has 1 to 14 characters, and the next value
// is accepted in the cycle after the units digit enters the output register.
// The output register holds that final character while the next value is
// converting. The user must write the separator through cfg_we_i/cfg_wdata_i
// only while no item is in flight; the block itself does not enforce this.
// The separator resets to a comma.
module int_to_decimal_grouped_core
  import itdg_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  itdg_in_if.sink           item_i,
  itdg_out_if.source        char_o,
  input  logic              cfg_we_i,
  input  logic [CHAR_W-1:0] cfg_wdata_i
);

  // Commands from the sequencer and status back from the datapath.
  itdg_cmd_t cmd;
  itdg_sts_t sts;

  // The sequencer owns the input handshake: it is ready only between items.
  itdg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_ready_o (item_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // The datapath holds the magnitude shifter, the BCD digits, the digit
  // pointer, the separator register and the output register.
  itdg_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .value_i     (item_i.value),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_ready_i (char_o.ready),
    .out_valid_o (char_o.valid),
    .char_o      (char_o.char_out),
    .last_o      (char_o.last)
  );

endmodule

### rtl/itdg_chk.sv
module itdg_chk
  import itdg_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [CHAR_W-1:0] char_i,
  input logic              last_i
);

  // A stalled output beat keeps its character and flag.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(char_i) && $stable(last_i))
    else $error("output beat changed while stalled");

  // Once a value is taken, the block is busy converting in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input accepted again during conversion");

  // Between items the only character that may still wait is a units digit.
  a_idle_pending_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i && out_valid_i |-> last_i)
    else $error("block idle with an unfinished number pending");

  // A value just taken is still converting, so no new character beat appears early.
  a_no_early_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> ##1 !(out_valid_i && !$past(out_valid_i)))
    else $error("character produced during conversion");

endmodule

bind int_to_decimal_grouped_core itdg_chk u_itdg_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (item_i.valid),
  .in_ready_i  (item_i.ready),
  .out_valid_i (char_o.valid),
  .out_ready_i (char_o.ready),
  .char_i      (char_o.char_out),
  .last_i      (char_o.last)
);

### tb/sv/itdg_text_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the formatter, predicts the text of every accepted
// value and compares each character beat against the oldest prediction.
module itdg_text_checker
  import itdg_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_ready_i,
  input  logic signed [VALUE_W-1:0] in_value_i,
  input  logic                      out_valid_i,
  input  logic                      out_ready_i,
  input  logic [CHAR_W-1:0]         out_char_i,
  input  logic                      out_last_i,
  input  logic                      cfg_we_i,
  input  logic [CHAR_W-1:0]         cfg_wdata_i,
  input  logic                      end_check_i,
  output int                        fail_count_o,
  output int                        pending_o,
  output int                        chars_seen_o
);

  localparam logic [CHAR_W-1:0] ASCII_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_MINUS  = 8'h2D;
  localparam logic [CHAR_W-1:0] SEP_AT_RESET = 8'd44;
  localparam int DIGIT_COUNT   = 10;
  localparam int POS_BILLIONS  = 0;
  localparam int POS_MILLIONS  = 3;
  localparam int POS_THOUSANDS = 6;
  localparam int POS_UNITS     = 9;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } text_beat_t;

  text_beat_t        expected_text[$];
  text_beat_t        oldest;
  logic [CHAR_W-1:0] sep_q;
  int                errors;
  bit                end_done;

  function automatic int unsigned place_of(input int pos);
    case (pos)
      0:       return 32'd1000000000;
      1:       return 32'd100000000;
      2:       return 32'd10000000;
      3:       return 32'd1000000;
      4:       return 32'd100000;
      5:       return 32'd10000;
      6:       return 32'd1000;
      7:       return 32'd100;
      8:       return 32'd10;
      default: return 32'd1;
    endcase
  endfunction

  task automatic push_char(input logic [CHAR_W-1:0] ch, input logic last);
    text_beat_t b;
    b.ch   = ch;
    b.last = last;
    expected_text.push_back(b);
  endtask

  // Sign first, then the digits of the magnitude without leading zeros, with
  // the separator after the billions, millions and thousands digits.
  task automatic predict_text(input logic [VALUE_W-1:0] raw);
    logic [VALUE_W-1:0] mag;
    int unsigned        digit;
    bit                 started;
    int                 pos;
    mag     = raw[VALUE_W-1] ? (32'd0 - raw) : raw;
    started = 1'b0;
    if (raw[VALUE_W-1]) begin
      push_char(ASCII_MINUS, 1'b0);
    end
    for (pos = 0; pos < DIGIT_COUNT; pos++) begin
      digit = mag / place_of(pos);
      mag   = mag % place_of(pos);
      if (started || digit != 0 || pos == POS_UNITS) begin
        started = 1'b1;
        if (pos == POS_UNITS) begin
          push_char(ASCII_ZERO + digit[CHAR_W-1:0], 1'b1);
        end else begin
          push_char(ASCII_ZERO + digit[CHAR_W-1:0], 1'b0);
          if (pos == POS_BILLIONS || pos == POS_MILLIONS || pos == POS_THOUSANDS) begin
            push_char(sep_q, 1'b0);
          end
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_q <= SEP_AT_RESET;
    end else begin
      // The oldest prediction is consumed before a new value is added, since a
      // character leaving in this cycle can never belong to the value entering.
      if (out_valid_i && out_ready_i) begin
        chars_seen_o <= chars_seen_o + 1;
        if (expected_text.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("unexpected char beat: char 0x%02h last %0b", out_char_i, out_last_i);
          end
        end else begin
          oldest = expected_text.pop_front();
          if (oldest.ch !== out_char_i || oldest.last !== out_last_i) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch on char %0d: expected char 0x%02h last %0b, got 0x%02h last %0b",
                       chars_seen_o, oldest.ch, oldest.last, out_char_i, out_last_i);
            end
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        predict_text(in_value_i);
      end
      if (cfg_we_i) begin
        sep_q <= cfg_wdata_i;
      end
      if (end_check_i && !end_done) begin
        end_done = 1'b1;
        if (expected_text.size() != 0) begin
          errors += expected_text.size();
          $display("%0d predicted characters never arrived", expected_text.size());
        end
      end
      pending_o    <= expected_text.size();
      fail_count_o <= errors;
    end
  end

endmodule

### tb/sv/int_to_decimal_grouped_core_tb.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the grouped decimal formatter. The checker beside
// the block does all prediction and comparison; this module only feeds
// values, writes the separator between phases, plays the receiver and
// decides pass or fail from the checker's failure count and its watchdog.
module int_to_decimal_grouped_core_tb;
  import itdg_pkg::*;

  // No beat at all for this many cycles means the block is hung. The longest
  // honest gap is the deliberate output hold-off plus one conversion.
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int LONG_HOLD      = 400;
  // Settle time that covers any work still in flight.
  localparam int SETTLE_CYCLES  = 60;
  localparam int BLOCK_COUNT    = 10;
  localparam int BLOCK_ITEMS    = 50;

  logic              clk_i  = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we;
  logic [CHAR_W-1:0] cfg_wdata;
  logic              end_check;

  int fail_count;
  int pending;
  int chars_seen;
  int items_sent;
  int sep_writes;
  int src_idle_pct;
  int snk_idle_pct;
  int hold_requests;
  int idle_run;

  itdg_in_if  item_bus ();
  itdg_out_if char_bus ();

  int_to_decimal_grouped_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_bus),
    .char_o      (char_bus),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  itdg_text_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (item_bus.valid),
    .in_ready_i   (item_bus.ready),
    .in_value_i   (item_bus.value),
    .out_valid_i  (char_bus.valid),
    .out_ready_i  (char_bus.ready),
    .out_char_i   (char_bus.char_out),
    .out_last_i   (char_bus.last),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .end_check_i  (end_check),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .chars_seen_o (chars_seen)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // The watchdog restarts on every beat in either direction.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((item_bus.valid && item_bus.ready) || (char_bus.valid && char_bus.ready)) begin
        idle_run <= 0;
      end else begin
        idle_run <= idle_run + 1;
      end
      if (idle_run >= WATCHDOG_LIMIT) begin
        $display("watchdog expired after %0d cycles without a beat", idle_run);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Receiver. It stalls at random by the current percentage, and when the
  // stimulus asks for it, it holds ready low for a long stretch so that the
  // block fills up and has to push back on its input.
  initial begin : receiver
    int holds_served;
    int hold_left;
    holds_served   = 0;
    hold_left      = 0;
    char_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        char_bus.ready <= 1'b0;
      end else if (holds_served != hold_requests) begin
        holds_served++;
        hold_left = LONG_HOLD;
        char_bus.ready <= 1'b0;
      end else begin
        char_bus.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  // Every call starts and ends just after a falling edge. Valid stays high
  // from one beat to the next unless the sender decides to idle first.
  task automatic send_value(input logic [VALUE_W-1:0] v);
    while ($urandom_range(99) < src_idle_pct) begin
      item_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    item_bus.valid <= 1'b1;
    item_bus.value <= v;
    do begin
      @(posedge clk_i);
    end while (!item_bus.ready);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain_text();
    item_bus.valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) begin
      @(negedge clk_i);
    end
  endtask

  // The separator may only change while no value is in flight.
  task automatic write_separator(input logic [CHAR_W-1:0] sep);
    drain_text();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= sep;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    sep_writes++;
    @(negedge clk_i);
  endtask

  function automatic int unsigned power_of_ten(input int k);
    int unsigned p;
    p = 1;
    repeat (k) p = p * 10;
    return p;
  endfunction

  // Values of a random digit count, the most common kind, so that every text length
  // shows up, plus fully random words, values next to powers of ten, and extremes.
  function automatic logic [VALUE_W-1:0] pick_value();
    int                 kind;
    int                 k;
    logic [VALUE_W-1:0] v;
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1, 2: begin
        v = $urandom();
      end
      3, 4, 5, 6: begin
        k = $urandom_range(1, 10);
        if (k == 10) begin
          v = $urandom();
        end else begin
          v = $urandom() % power_of_ten(k);
        end
      end
      7, 8: begin
        k = $urandom_range(0, 9);
        v = power_of_ten(k) + $urandom_range(0, 2) - 1;
      end
      default: begin
        case ($urandom_range(0, 3))
          0:       v = 32'h0000_0000;
          1:       v = 32'h7FFF_FFFF;
          2:       v = 32'h8000_0000;
          default: v = 32'h8000_0001;
        endcase
      end
    endcase
    if (kind >= 3 && kind <= 8 && $urandom_range(0, 1) == 1) begin
      v = 32'd0 - v;
    end
    return v;
  endfunction

  function automatic logic [CHAR_W-1:0] separator_for(input int blk);
    case (blk)
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h35;  // a digit byte, passed through unchecked
      3:       return 8'h2D;  // same byte as the minus sign
      4:       return 8'h2E;
      5:       return 8'h20;
      default: return CHAR_W'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin : stimulus
    logic [VALUE_W-1:0] directed [22];
    int blk;
    int n;
    directed = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, 32'd999, 32'd1000,
                 -32'sd1000, 32'd999999, 32'd1000000, 32'd999999999,
                 32'd1000000000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
                 32'd1234567, -32'sd987654321, 32'd100, 32'd1000001000,
                 32'h5555_5555, 32'hAAAA_AAAA, 32'd2000000002};
    item_bus.valid = 1'b0;
    item_bus.value = '0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    end_check      = 1'b0;
    src_idle_pct   = 23;
    snk_idle_pct   = 53;
    hold_requests  = 0;
    items_sent     = 0;
    sep_writes     = 0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed values with the comma the separator resets to: zero, the
    // edges of each digit group, both extremes and the most negative value.
    foreach (directed[i]) begin
      send_value(directed[i]);
    end

    for (blk = 0; blk < BLOCK_COUNT; blk++) begin
      write_separator(separator_for(blk));
      if (blk < 3) begin
        src_idle_pct = 23;
        snk_idle_pct = 53;
      end else if (blk < 6) begin
        src_idle_pct = 53;
        snk_idle_pct = 23;
      end else begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      for (n = 0; n < BLOCK_ITEMS; n++) begin
        // With no sender idling, a long output stall backs the block up
        // while values keep being offered.
        if (blk == 7 && n == 10) begin
          hold_requests++;
        end
        // Here the sender stops until every character so far has come out.
        if (blk == 8 && n == 25) begin
          drain_text();
        end
        send_value(pick_value());
      end
    end

    drain_text();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    end_check <= 1'b1;
    repeat (2) @(negedge clk_i);

    $display("Formatted %0d values into %0d characters under %0d separator settings",
             items_sent, chars_seen, sep_writes + 1);
    $display("Idling swapped between sender and receiver, with one long stall and one drain");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d failures", fail_count);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/itdg_pkg.sv
rtl/itdg_if.sv
rtl/itdg_dp.sv
rtl/itdg_ctrl.sv
rtl/int_to_decimal_grouped_core.sv
rtl/itdg_chk.sv
tb/sv/itdg_text_checker.sv
tb/sv/int_to_decimal_grouped_core_tb.sv
